>>> sv/lbps_pkg.sv
`default_nettype none
package lbps_pkg;

	localparam int PAT_W    = 4;
	localparam int PH_W     = 4;
	localparam int DUR_W    = 19;
	localparam int LT_W     = 20;
	localparam int ROM_ROWS = 13;
	localparam int ROM_COLS = 16;

	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_SET     = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	localparam logic [PAT_W-1:0] PAT_OFF   = 4'd0;
	localparam logic [PAT_W-1:0] PAT_ON    = 4'd1;
	localparam logic [PAT_W-1:0] PAT_BLINK = 4'd12;

	localparam logic [LT_W-1:0] ENDLESS = 20'h80000;

	localparam logic [DUR_W-1:0] DUR_TABLE [ROM_ROWS][ROM_COLS] = '{
		'{0: 19'd500, 1: 19'd10, default: 19'd0},
		'{0: 19'd10, 1: 19'd500, default: 19'd0},
		'{0: 19'd100, 1: 19'd200, 2: 19'd100, 3: 19'd200, 4: 19'd400, default: 19'd0},
		'{0: 19'd500, 1: 19'd500, default: 19'd0},
		'{0: 19'd250, 1: 19'd250, default: 19'd0},
		'{0: 19'd125, 1: 19'd125, default: 19'd0},
		'{0: 19'd50, 1: 19'd50, default: 19'd0},
		'{0: 19'd200, 1: 19'd100, default: 19'd0},
		'{0: 19'd100, 1: 19'd100, default: 19'd0},
		'{10: 19'd400, 11: 19'd0, 12: 19'd0, 13: 19'd0, 14: 19'd0, 15: 19'd0,
			default: 19'd100},
		'{0: 19'd10, 1: 19'd300000, default: 19'd0},
		'{0: 19'd450, 1: 19'd50, default: 19'd0},
		'{0: 19'd70, 1: 19'd30, default: 19'd0}
	};

	localparam logic [LT_W-1:0] LIFE_TABLE [ROM_ROWS] = '{
		20'd500, 20'd510, ENDLESS, ENDLESS, ENDLESS, ENDLESS, ENDLESS,
		20'd120200, 20'd120100, 20'd120400, 20'd300020, ENDLESS, 20'd100
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [PAT_W-1:0] pat;
		logic [PH_W-1:0]  ph;
		logic [DUR_W-1:0] rem;
		logic [DUR_W-1:0] life;
		logic             running;
	} led_entry_t;

	typedef struct packed {
		logic load;
		logic sweep;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic last;
	} ctl_sts_t;

	function automatic logic [DUR_W-1:0] dur_rom(input logic [PAT_W-1:0] p,
			input logic [PH_W-1:0] ph);
		logic [DUR_W-1:0] d;
		d = '0;
		if (p < 4'(ROM_ROWS)) begin
			d = DUR_TABLE[p][ph];
		end
		return d;
	endfunction

	function automatic logic [LT_W-1:0] life_rom(input logic [PAT_W-1:0] p);
		logic [LT_W-1:0] l;
		l = '0;
		if (p < 4'(ROM_ROWS)) begin
			l = LIFE_TABLE[p];
		end
		return l;
	endfunction

endpackage
`default_nettype wire

>>> sv/lbps_if.sv
`default_nettype none
interface lbps_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [3:0] led_index;
	logic       apply_all;
	logic [3:0] pattern;

	modport source(output valid, output kind, output led_index, output apply_all,
		output pattern, input ready);
	modport sink(input valid, input kind, input led_index, input apply_all,
		input pattern, output ready);
endinterface

interface lbps_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] led_levels;
	logic [3:0]  current_pattern;
	logic        set_error;

	modport source(output valid, output led_levels, output current_pattern,
		output set_error, input ready);
	modport sink(input valid, input led_levels, input current_pattern,
		input set_error, output ready);
endinterface
`default_nettype wire

>>> sv/lbps_ctrl.sv
`default_nettype none
module lbps_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cmd_valid,
	output logic                  cmd_ready,
	output logic                  rsp_valid,
	input  wire                   rsp_ready,
	output lbps_pkg::ctl_cmd_t    ctl,
	input  lbps_pkg::ctl_sts_t    sts
);

	lbps_pkg::state_t state_q;
	lbps_pkg::state_t state_d;
	logic             rsp_valid_q;
	logic             rsp_free;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == lbps_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lbps_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			lbps_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = lbps_pkg::ST_SWEEP;
				end
			end
			lbps_pkg::ST_SWEEP: begin
				ctl.sweep = 1'b1;
				if (sts.last) begin
					state_d = lbps_pkg::ST_DRAIN;
				end
			end
			lbps_pkg::ST_DRAIN: begin
				state_d = lbps_pkg::ST_EMIT;
			end
			lbps_pkg::ST_EMIT: begin
				if (rsp_free) begin
					ctl.emit = 1'b1;
					state_d  = lbps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lbps_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> sv/lbps_dp.sv
`default_nettype none
module lbps_dp #(
	parameter int NUM_LEDS          = 16,
	parameter int NUM_PATTERNS      = 13,
	parameter int STEPS_PER_PATTERN = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lbps_pkg::ctl_cmd_t  ctl,
	output lbps_pkg::ctl_sts_t  sts,
	input  wire  [1:0]          kind,
	input  wire  [3:0]          led_index,
	input  wire                 apply_all,
	input  wire  [3:0]          pattern,
	output logic [15:0]         led_levels,
	output logic [3:0]          current_pattern,
	output logic                set_error
);

	localparam int LW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int CMPW = 6;
	localparam logic [3:0] NO_PATTERN = 4'(NUM_PATTERNS);
	localparam lbps_pkg::led_entry_t RESET_ENTRY = '{pat: NO_PATTERN, ph: '0,
		rem: '0, life: '0, running: 1'b0};

	lbps_pkg::led_entry_t mem [NUM_LEDS];
	logic [NUM_LEDS-1:0]  ent_vld_q;
	logic [NUM_LEDS-1:0]  level_q;

	logic [1:0]  kind_q;
	logic [3:0]  idx_q;
	logic        all_q;
	logic [3:0]  pat_q;
	logic        err_q;
	logic [3:0]  cap_pat_q;
	logic [LW-1:0] cnt_q;

	logic                 proc_s1;
	logic [LW-1:0]        addr_s1;
	logic                 vld_s1;
	lbps_pkg::led_entry_t rd_s1;

	logic        in_err;
	lbps_pkg::led_entry_t old_e;
	lbps_pkg::led_entry_t new_e;
	logic        lvl_old;
	logic        lvl_new;
	logic        hit;
	logic        do_start;
	logic [3:0]  st_p;
	logic [3:0]  st_ph;
	logic [lbps_pkg::DUR_W-1:0] st_life;
	logic [lbps_pkg::LT_W-1:0]  lt;
	logic [lbps_pkg::LT_W-1:0]  old_lt;
	logic [lbps_pkg::LT_W-1:0]  pat_lt;
	logic        st_ok;
	logic        old_ok;
	logic        pat_ok_q;
	logic [lbps_pkg::DUR_W-1:0] d_ph;
	logic [lbps_pkg::DUR_W-1:0] d_zero;
	logic [lbps_pkg::DUR_W-1:0] d;
	logic [3:0]  ph0;
	logic        limited;

	assign in_err = (kind == lbps_pkg::KIND_SET) &&
		(!((pattern < 4'(NUM_PATTERNS)) && (pattern < 4'(lbps_pkg::ROM_ROWS))) ||
		(!apply_all && (CMPW'(led_index) >= CMPW'(NUM_LEDS))));

	assign sts.last = (cnt_q == LW'(NUM_LEDS - 1));

	// item and result registers, memory read stage and memory write-back
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q    <= kind;
			idx_q     <= led_index;
			all_q     <= apply_all;
			pat_q     <= pattern;
			err_q     <= in_err;
		end
		if (ctl.emit) begin
			led_levels      <= 16'(level_q);
			current_pattern <= cap_pat_q;
			set_error       <= err_q;
		end
		if (ctl.sweep) begin
			rd_s1   <= mem[cnt_q];
			vld_s1  <= ent_vld_q[cnt_q];
			addr_s1 <= cnt_q;
		end
		if (proc_s1) begin
			mem[addr_s1] <= new_e;
		end
		if (ctl.load) begin
			cap_pat_q <= NO_PATTERN;
		end else if (proc_s1 && hit) begin
			cap_pat_q <= new_e.pat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			level_q   <= '0;
			cnt_q     <= '0;
			proc_s1   <= 1'b0;
		end else begin
			proc_s1 <= ctl.sweep;
			if (ctl.load) begin
				cnt_q <= '0;
			end else if (ctl.sweep) begin
				cnt_q <= cnt_q + LW'(1);
			end
			if (proc_s1) begin
				ent_vld_q[addr_s1] <= 1'b1;
				level_q[addr_s1]   <= lvl_new;
			end
		end
	end

	assign old_e    = vld_s1 ? rd_s1 : RESET_ENTRY;
	assign lvl_old  = level_q[addr_s1];
	assign hit      = (CMPW'(addr_s1) == CMPW'(idx_q));
	assign old_lt   = lbps_pkg::life_rom(old_e.pat);
	assign pat_lt   = lbps_pkg::life_rom(pat_q);
	assign old_ok   = (old_e.pat < 4'(NUM_PATTERNS)) && (old_e.pat < 4'(lbps_pkg::ROM_ROWS));
	assign pat_ok_q = (pat_q < 4'(NUM_PATTERNS)) && (pat_q < 4'(lbps_pkg::ROM_ROWS));

	// pick the per-LED action
	always_comb begin
		do_start = 1'b0;
		st_p     = old_e.pat;
		st_ph    = old_e.ph;
		st_life  = old_e.life;
		unique case (kind_q)
			lbps_pkg::KIND_TICK: begin
				if (old_e.running && (old_e.rem <= 19'd1)) begin
					do_start = 1'b1;
				end
			end
			lbps_pkg::KIND_SET: begin
				if (!err_q && (all_q || hit)) begin
					do_start = 1'b1;
					st_p     = pat_q;
					st_ph    = '0;
					st_life  = (pat_ok_q && !pat_lt[19]) ? pat_lt[18:0] : '0;
				end
			end
			lbps_pkg::KIND_RESTART: begin
				if (hit && ((old_e.pat == lbps_pkg::PAT_ON) ||
						(old_e.pat == lbps_pkg::PAT_BLINK))) begin
					do_start = 1'b1;
					st_ph    = '0;
					st_life  = (old_ok && !old_lt[19]) ? old_lt[18:0] : '0;
				end
			end
			default: begin
				do_start = 1'b0;
			end
		endcase
	end

	// phase start
	assign st_ok   = (st_p < 4'(NUM_PATTERNS)) && (st_p < 4'(lbps_pkg::ROM_ROWS));
	assign lt      = lbps_pkg::life_rom(st_p);
	assign limited = !lt[19];
	assign d_ph    = lbps_pkg::dur_rom(st_p, st_ph);
	assign d_zero  = lbps_pkg::dur_rom(st_p, '0);
	assign ph0     = ((5'(st_ph) >= 5'(STEPS_PER_PATTERN)) || (d_ph == '0)) ? '0 : st_ph;
	assign d       = (ph0 == '0) ? d_zero : d_ph;

	always_comb begin
		new_e   = old_e;
		lvl_new = lvl_old;
		if (do_start) begin
			new_e.pat  = st_p;
			new_e.life = st_life;
			if (!st_ok || (limited && !((st_life != '0) && (st_life >= d)))) begin
				new_e.running = 1'b0;
				new_e.ph      = '0;
			end else begin
				if (limited) begin
					new_e.life = st_life - d;
				end
				if (ph0[0]) begin
					if (st_p != lbps_pkg::PAT_OFF) begin
						lvl_new = 1'b1;
					end
				end else begin
					lvl_new = 1'b0;
				end
				new_e.rem     = d;
				new_e.ph      = ph0 + 4'd1;
				new_e.running = 1'b1;
			end
		end else if ((kind_q == lbps_pkg::KIND_TICK) && old_e.running) begin
			new_e.rem = old_e.rem - 19'd1;
		end
	end

endmodule
`default_nettype wire

>>> sv/led_blink_pattern_sequencer_unit.sv
// LED blink pattern sequencer.
// cmd channel (valid/ready): one word per event - kind 0 is a 1 ms tick,
// 1 sets a pattern on led_index (or every LED with apply_all), 2 asks for a
// restart of led_index, which acts only on the steady-on and blink patterns.
// rsp channel (valid/ready): exactly one word per cmd word, in order, with
// the levels of LEDs 0..15, the pattern of led_index after the event (13 for
// none or an index beyond the LEDs) and set_error for a rejected set.
// Each word walks the per-LED state memory once, one entry a cycle through a
// read / update / write-back path, and a new word is taken only once the
// result of the last one has moved to the rsp register; while the receiver
// keeps up, the memory walk sets the rate.
// If the receiver stalls, the result is held in the rsp register; the next
// cmd word is still accepted and processed, and waits at the end of its walk
// until the rsp register is free.
// Reset: all LEDs dark and stopped with no pattern; the state memory reads
// as cleared through per-entry valid flags, so no clearing pass is needed.
`default_nettype none
module led_blink_pattern_sequencer_unit #(
	parameter int NUM_LEDS          = 16,
	parameter int NUM_PATTERNS      = 13,
	parameter int STEPS_PER_PATTERN = 16
) (
	input wire         clk,
	input wire         arst_n,
	lbps_cmd_if.sink   cmd,
	lbps_rsp_if.source rsp
);

	lbps_pkg::ctl_cmd_t ctl;
	lbps_pkg::ctl_sts_t sts;

	lbps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	lbps_dp #(
		.NUM_LEDS          (NUM_LEDS),
		.NUM_PATTERNS      (NUM_PATTERNS),
		.STEPS_PER_PATTERN (STEPS_PER_PATTERN)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.kind            (cmd.kind),
		.led_index       (cmd.led_index),
		.apply_all       (cmd.apply_all),
		.pattern         (cmd.pattern),
		.led_levels      (rsp.led_levels),
		.current_pattern (rsp.current_pattern),
		.set_error       (rsp.set_error)
	);

endmodule
`default_nettype wire
